// ----- design/selective_repeat_sender_tracker_unit_assert.svh -----
// assertion macros for the selective repeat sender tracker
// used by the top level only
`ifndef SELECTIVE_REPEAT_SENDER_TRACKER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_TRACKER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SRST_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srst_pkg.sv -----
// shared types and constants for the selective repeat sender tracker
// no dependencies
`default_nettype none
package srst_pkg;
  localparam int MaxChunks = 64;
  localparam int TimeBits  = 32;
  localparam int IdxBits   = $clog2(MaxChunks);
  localparam int CntBits   = IdxBits + 1;

  localparam logic [1:0] ActSend  = 2'd0;
  localparam logic [1:0] ActAck   = 2'd1;
  localparam logic [1:0] ActCheck = 2'd2;
  localparam logic [1:0] ActNone  = 2'd3;

  localparam logic [1:0] EvNew    = 2'd0;
  localparam logic [1:0] EvAck    = 2'd1;
  localparam logic [1:0] EvRetx   = 2'd2;

  localparam logic CfgChunkCount = 1'b0;
  localparam logic CfgTimeout    = 1'b1;

  localparam logic [6:0]  ResetChunks  = 7'd64;
  localparam logic [31:0] ResetTimeout = 32'd100;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0]          action;
    logic [IdxBits-1:0]  id;
    logic [TimeBits-1:0] now;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]          kind;
    logic [IdxBits-1:0]  id;
    logic [31:0]         rtt;
    logic [6:0]          acked;
    logic [31:0]         retx;
    logic                done;
    logic                last;
  } res_t;
endpackage
`default_nettype wire

// ----- design/srst_front.sv -----
// front: accepts items, drops ignored ones, queues commands (2 deep)
// depends on srst_pkg
`default_nettype none
module srst_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [1:0]    action_i,
  input  wire logic [15:0]   ack_chunk_i,
  input  wire logic [31:0]   now_time_i,
  input  wire logic [6:0]    count_i,
  output logic               cmd_valid_o,
  output srst_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_take_i
);
  import srst_pkg::*;

  cmd_t       q_mem [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, wr;

  // ack ids at or above the live count are dropped here; unused action code too
  always_comb begin
    keep = 1'b1;
    if (action_i == ActNone) keep = 1'b0;
    if (action_i == ActAck && {9'd0, count_i} <= ack_chunk_i) keep = 1'b0;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign wr          = push_i && !full_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  // queue pointers
  always_comb begin
    wp_d  = wp_q ^ wr;
    rp_d  = rp_q ^ cmd_take_i;
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, cmd_take_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem[wp_q] <= '{action: action_i, id: ack_chunk_i[IdxBits-1:0], now: now_time_i};
    end
  end
endmodule
`default_nettype wire

// ----- design/srst_back.sv -----
// back: sequencer over the stamp memory, ack bits and counters
// depends on srst_pkg
`default_nettype none
module srst_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire srst_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  input  wire logic [6:0]    count_i,
  input  wire logic [31:0]   timeout_i,
  output logic               res_valid_o,
  output srst_pkg::res_t     res_o,
  input  wire logic          res_take_i
);
  import srst_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StScan  = 5'b00100,
    StOut   = 5'b01000,
    StFlush = 5'b10000
  } state_e;

  state_e              st_q;
  cmd_t                cur_q;
  logic [TimeBits-1:0] stamp_mem [MaxChunks];
  logic [TimeBits-1:0] rd_q;
  logic [MaxChunks-1:0] ack_q;
  logic [MaxChunks-1:0] sent_q;
  logic [CntBits-1:0]  next_q, acked_q, idx_q, lim_q;
  logic [31:0]         retx_q, last_chk_q, retx_inc;
  res_t                res_q, stg_q, stg_fin;
  logic                res_full_q, stg_v_q;
  logic [IdxBits-1:0]  cur_idx, rd_addr;
  logic [TimeBits-1:0] stamp, age;
  logic                last_idx, slot_free, hit, scan_go, res_load;
  logic [CntBits-1:0]  lim_c;

  assign cmd_take_o  = (st_q == StIdle) && cmd_valid_i;
  assign res_valid_o = res_full_q;
  assign res_o       = res_q;

  // unsent chunks read as zero stamp
  assign cur_idx   = idx_q[IdxBits-1:0];
  assign stamp     = sent_q[cur_idx] ? rd_q : '0;
  assign age       = cur_q.now - stamp;
  assign last_idx  = (idx_q + 1'b1 >= lim_q);
  assign lim_c     = (next_q < count_i) ? next_q : count_i;
  assign slot_free = !res_full_q || res_take_i;
  assign hit       = !ack_q[cur_idx] && (age > timeout_i);
  assign scan_go   = hit && (!stg_v_q || slot_free);
  assign retx_inc  = (retx_q != '1) ? retx_q + 32'd1 : retx_q;
  // during the gap cycle the next chunk's stamp is fetched
  assign rd_addr   = cmd_take_o ? cmd_i.id : ((st_q == StOut) ? cur_idx + 1'b1 : cur_idx);

  // held hit released with the last flag at the end of a scan
  always_comb begin
    stg_fin      = stg_q;
    stg_fin.last = 1'b1;
  end

  // result register load
  always_comb begin
    res_load = 1'b0;
    unique case (st_q)
      StRead: begin
        if (slot_free) begin
          if (cur_q.action == ActSend) res_load = (next_q < count_i);
          else if (cur_q.action == ActAck) res_load = !ack_q[cur_idx];
        end
      end
      StScan:  res_load = hit && stg_v_q && slot_free;
      StFlush: res_load = slot_free;
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= stamp_mem[rd_addr];
    if (st_q == StIdle && cmd_valid_i && cmd_i.action == ActSend && next_q < count_i)
      stamp_mem[next_q[IdxBits-1:0]] <= cmd_i.now;
    else if (st_q == StScan && scan_go)
      stamp_mem[cur_idx] <= cur_q.now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ack_q <= '0; sent_q <= '0; next_q <= '0; acked_q <= '0;
      retx_q <= '0; last_chk_q <= '0; res_full_q <= 1'b0; idx_q <= '0;
      lim_q <= '0; stg_v_q <= 1'b0; stg_q <= '0; cur_q <= '0; res_q <= '0;
    end else begin
      res_full_q <= res_load || (res_full_q && !res_take_i);
      unique case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cur_q <= cmd_i;
            idx_q <= (cmd_i.action == ActAck) ? {1'b0, cmd_i.id} : '0;
            st_q  <= StRead;
          end
        end
        // wait for a free result slot, then do the command
        StRead: begin
          if (slot_free) begin
            st_q <= StIdle;
            unique case (cur_q.action)
              ActSend: if (next_q < count_i) begin
                sent_q[next_q[IdxBits-1:0]] <= 1'b1;
                next_q <= next_q + 1'b1;
                res_q  <= '{EvNew, next_q[IdxBits-1:0], 32'd0, 7'(acked_q),
                            retx_q, (acked_q >= count_i), 1'b1};
              end
              ActAck: if (!ack_q[cur_idx]) begin
                ack_q[cur_idx] <= 1'b1;
                acked_q <= acked_q + 1'b1;
                res_q   <= '{EvAck, cur_idx, age, 7'(acked_q + 1'b1),
                             retx_q, (acked_q + 1'b1 >= count_i), 1'b1};
              end
              default: if (cur_q.now - last_chk_q > timeout_i) begin
                last_chk_q <= cur_q.now;
                if (lim_c != '0) begin
                  lim_q <= lim_c;
                  st_q  <= StScan;
                end
              end
            endcase
          end else begin
            st_q <= StRead;
          end
        end
        // one chunk per visit; a hit is held until the next hit or the end
        StScan: begin
          if (scan_go) begin
            if (stg_v_q) res_q <= stg_q;
            retx_q  <= retx_inc;
            stg_q   <= '{EvRetx, cur_idx, 32'd0, 7'(acked_q), retx_inc,
                         (acked_q >= count_i), 1'b0};
            stg_v_q <= 1'b1;
            st_q    <= StOut;
          end else if (!hit) begin
            st_q <= StOut;
          end
        end
        // step to the next chunk while its stamp is read
        StOut: begin
          if (last_idx) st_q <= stg_v_q ? StFlush : StIdle;
          else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= StScan;
          end
        end
        StFlush: begin
          if (slot_free) begin
            res_q   <= stg_fin;
            stg_v_q <= 1'b0;
            st_q    <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/selective_repeat_sender_tracker_unit.sv -----
// top level of the selective repeat sender tracker
// depends on srst_pkg, srst_front, srst_back and the assertion header
//
// channel   direction  handshake       payload
// in        push/full  push & !full    action, ack_chunk, now_time
// out       empty/pop  pop & !empty    event kind, chunk, rtt, counters, flags
// cfg       write      cfg_we          cfg_idx, cfg_data
//
// send and ack pass StIdle (stamp-memory read), then StRead (update) in the back end.
// a timeout check passes StIdle and StRead, then StScan and StOut for each chunk below
// the scan limit, and StFlush releases a held final hit; one read and one write port.
// reset clears all control state; stamps of unsent chunks read as zero.
// a full result register stalls the back end; the 2-entry queue lets input run on.
`default_nettype none
`include "selective_repeat_sender_tracker_unit_assert.svh"
module selective_repeat_sender_tracker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] ack_chunk_i,
  input  wire logic [31:0] now_time_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       event_kind_o,
  output logic [5:0]       chunk_id_o,
  output logic [31:0]      round_trip_o,
  output logic [6:0]       acked_total_o,
  output logic [31:0]      retransmit_total_o,
  output logic             transfer_done_o,
  output logic             last_of_run_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import srst_pkg::*;

  logic [6:0]  count_q, count_eff;
  logic [31:0] timeout_q;
  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ResetChunks; timeout_q <= ResetTimeout;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgChunkCount) count_q <= cfg_data_i[6:0];
      else timeout_q <= cfg_data_i;
    end
  end
  assign count_eff = (count_q > 7'(MaxChunks)) ? 7'(MaxChunks) : count_q;

  srst_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .action_i, .ack_chunk_i,
    .now_time_i, .count_i(count_eff), .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .cmd_take_i(cmd_take)
  );

  srst_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .count_i(count_eff), .timeout_i(timeout_q), .res_valid_o(res_valid),
    .res_o(res), .res_take_i(pop && !empty)
  );

  assign empty              = !res_valid;
  assign event_kind_o       = res.kind;
  assign chunk_id_o         = res.id;
  assign round_trip_o       = res.rtt;
  assign acked_total_o      = res.acked;
  assign retransmit_total_o = res.retx;
  assign transfer_done_o    = res.done;
  assign last_of_run_o      = res.last;

  `SRST_ASSERT(a_rtt_kind, !empty && event_kind_o != EvAck, round_trip_o == '0, "rtt on non-ack")
  `SRST_ASSERT(a_acked_le, !empty, acked_total_o <= 7'(MaxChunks), "acked total too large")
  `SRST_ASSERT_NEXT(a_hold, !empty && !pop, !empty, "result dropped")
endmodule
`default_nettype wire
